// File: sv/point_attractor_velocity_kick_core_defines.svh
// Assertion macros for the point attractor core.
// Each checks on the rising edge of clk and is off while arst_n is low.
`ifndef POINT_ATTRACTOR_VELOCITY_KICK_CORE_DEFINES_SVH
`define POINT_ATTRACTOR_VELOCITY_KICK_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PAVK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PAVK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PAVK_ASSERT(lbl, prop, msg)
`define PAVK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/pavk_pkg.sv
`default_nettype none
package pavk_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int RAD_W         = 31;
	localparam int MAG_W         = 31;
	localparam int SQ_W          = 63;
	localparam int ROOT_W        = 32;
	localparam int KICK_W        = 32;

	typedef enum logic [1:0] {
		CFG_ATTRACTOR_X  = 2'd0,
		CFG_ATTRACTOR_Y  = 2'd1,
		CFG_STRENGTH     = 2'd2,
		CFG_EFFECT_RADIUS = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] vel_x;
		logic signed [COORD_W-1:0] vel_y;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] new_vel_x;
		logic signed [COORD_W-1:0] new_vel_y;
		logic                      within_reach;
	} result_t;

endpackage
`default_nettype wire

// File: sv/pavk_isqrt.sv
`default_nettype none
// Pipelined integer square root, one root bit per stage.
module pavk_isqrt #(
	parameter int RTW = pavk_pkg::ROOT_W,
	parameter int SW  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [2*RTW-1:0] in_val,
	input  logic [SW-1:0]    in_sb,
	output logic             out_valid,
	output logic [RTW-1:0]   out_root,
	output logic [2*RTW-1:0] out_val,
	output logic [SW-1:0]    out_sb
);

	localparam int RW = RTW + 3;

	logic [RTW-1:0]   vld_s;
	logic [RW-1:0]    rem_s  [RTW];
	logic [RTW-1:0]   root_s [RTW];
	logic [2*RTW-1:0] val_s  [RTW];
	logic [SW-1:0]    sb_s   [RTW];

	logic [RTW-1:0]   vld_i;
	logic [RW-1:0]    rem_i  [RTW];
	logic [RTW-1:0]   root_i [RTW];
	logic [2*RTW-1:0] val_i  [RTW];
	logic [SW-1:0]    sb_i   [RTW];

	logic [RW-1:0]    cat_c   [RTW];
	logic [RW-1:0]    trial_c [RTW];
	logic [RTW-1:0]   ge_c;
	logic [RW-1:0]    rem_c   [RTW];
	logic [RTW-1:0]   root_c  [RTW];

	always_comb begin
		vld_i[0]  = in_valid;
		rem_i[0]  = '0;
		root_i[0] = '0;
		val_i[0]  = in_val;
		sb_i[0]   = in_sb;
		for (int k = 1; k < RTW; k++) begin
			vld_i[k]  = vld_s[k-1];
			rem_i[k]  = rem_s[k-1];
			root_i[k] = root_s[k-1];
			val_i[k]  = val_s[k-1];
			sb_i[k]   = sb_s[k-1];
		end
	end

	// remainder never exceeds twice the root, so its top two bits are zero
	always_comb begin
		for (int k = 0; k < RTW; k++) begin
			cat_c[k]   = {rem_i[k][RW-3:0], val_i[k][2*(RTW-1-k)+1 -: 2]};
			trial_c[k] = RW'({root_i[k], 2'b01});
			ge_c[k]    = cat_c[k] >= trial_c[k];
			rem_c[k]   = ge_c[k] ? cat_c[k] - trial_c[k] : cat_c[k];
			root_c[k]  = {root_i[k][RTW-2:0], ge_c[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RTW; k++) begin
				rem_s[k]  <= rem_c[k];
				root_s[k] <= root_c[k];
				val_s[k]  <= val_i[k];
				sb_s[k]   <= sb_i[k];
			end
		end
	end

	assign out_valid = vld_s[RTW-1];
	assign out_root  = root_s[RTW-1];
	assign out_val   = val_s[RTW-1];
	assign out_sb    = sb_s[RTW-1];

endmodule
`default_nettype wire

// File: sv/pavk_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
// in_hi is the top of the dividend and must be below in_den.
module pavk_div #(
	parameter int DENW  = 32,
	parameter int QW    = 17,
	parameter int LANES = 2,
	parameter int SW    = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [DENW-1:0]             in_den,
	input  logic [LANES-1:0][DENW-1:0]  in_hi,
	input  logic [LANES-1:0][QW-1:0]    in_lo,
	input  logic [SW-1:0]               in_sb,
	output logic                        out_valid,
	output logic [LANES-1:0][QW-1:0]    out_q,
	output logic [SW-1:0]               out_sb
);

	logic [QW-1:0]                 vld_s;
	logic [DENW-1:0]               den_s [QW];
	logic [LANES-1:0][DENW-1:0]    hi_s  [QW];
	logic [LANES-1:0][QW-1:0]      lo_s  [QW];
	logic [LANES-1:0][QW-1:0]      q_s   [QW];
	logic [SW-1:0]                 sb_s  [QW];

	logic [QW-1:0]                 vld_i;
	logic [DENW-1:0]               den_i [QW];
	logic [LANES-1:0][DENW-1:0]    hi_i  [QW];
	logic [LANES-1:0][QW-1:0]      lo_i  [QW];
	logic [LANES-1:0][QW-1:0]      q_i   [QW];
	logic [SW-1:0]                 sb_i  [QW];

	logic [LANES-1:0][DENW:0]      cat_c [QW];
	logic [LANES-1:0]              ge_c  [QW];
	logic [LANES-1:0][DENW-1:0]    hi_c  [QW];
	logic [LANES-1:0][QW-1:0]      q_c   [QW];

	always_comb begin
		vld_i[0] = in_valid;
		den_i[0] = in_den;
		hi_i[0]  = in_hi;
		lo_i[0]  = in_lo;
		q_i[0]   = '0;
		sb_i[0]  = in_sb;
		for (int k = 1; k < QW; k++) begin
			vld_i[k] = vld_s[k-1];
			den_i[k] = den_s[k-1];
			hi_i[k]  = hi_s[k-1];
			lo_i[k]  = lo_s[k-1];
			q_i[k]   = q_s[k-1];
			sb_i[k]  = sb_s[k-1];
		end
	end

	always_comb begin
		for (int k = 0; k < QW; k++) begin
			for (int l = 0; l < LANES; l++) begin
				cat_c[k][l] = {hi_i[k][l], lo_i[k][l][QW-1-k]};
				ge_c[k][l]  = cat_c[k][l] >= {1'b0, den_i[k]};
				hi_c[k][l]  = ge_c[k][l] ? DENW'(cat_c[k][l] - {1'b0, den_i[k]})
				                         : cat_c[k][l][DENW-1:0];
				q_c[k][l]   = {q_i[k][l][QW-2:0], ge_c[k][l]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				den_s[k] <= den_i[k];
				hi_s[k]  <= hi_c[k];
				lo_s[k]  <= lo_i[k];
				q_s[k]   <= q_c[k];
				sb_s[k]  <= sb_i[k];
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_q     = q_s[QW-1];
	assign out_sb    = sb_s[QW-1];

endmodule
`default_nettype wire

// File: sv/pavk_skid.sv
`default_nettype none
`include "point_attractor_velocity_kick_core_defines.svh"
// Two-entry output buffer; space stays high while one item waits.
module pavk_skid #(
	parameter int W = 65
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         space,
	output logic         valid,
	input  logic         ready,
	output logic [W-1:0] data
);

	logic [W-1:0] mem_q [2];
	logic [1:0]   cnt_q;
	logic         wr_q;
	logic         rd_q;
	logic         pop;

	assign pop   = valid & ready;
	assign space = cnt_q != 2'd2;
	assign valid = cnt_q != 2'd0;
	assign data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	`PAVK_ASSERT(a_no_overflow, push |-> space, "item pushed into full output buffer")
	`PAVK_ASSERT_NEXT(a_fill_step, cnt_q == 2'd0, cnt_q != 2'd2, "output buffer filled by two at once")
	`PAVK_ASSERT_NEXT(a_drain, cnt_q == 2'd1 && pop && !push, cnt_q == 2'd0, "output buffer failed to drain")

endmodule
`default_nettype wire

// File: sv/point_attractor_velocity_kick_core.sv
// Q16.16 by default. Throughput, unless the full output buffer holds back s7:
// one item per cycle; the square root and both dividers are fully
// pipelined, one result bit per stage, and the output has a two-entry buffer.
// Reset: arst_n clears all valid bits, the output buffer and the four
// configuration registers (attractor, strength and radius read as zero).
`default_nettype none
module point_attractor_velocity_kick_core #(
	parameter int FRAC_BITS = pavk_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  pavk_pkg::item_t                    item,
	output logic                               result_valid,
	input  logic                               result_ready,
	output pavk_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  pavk_pkg::cfg_idx_t                 cfg_index,
	input  logic [pavk_pkg::COORD_W-1:0]       cfg_data
);

	localparam int CW    = pavk_pkg::COORD_W;
	localparam int MW    = pavk_pkg::MAG_W;
	localparam int SQW   = pavk_pkg::SQ_W;
	localparam int RTW   = pavk_pkg::ROOT_W;
	localparam int KW    = pavk_pkg::KICK_W;
	localparam int UQ_W  = FRAC_BITS + 1;       // unit vector component, <= 1.0
	localparam int NUM_W = CW + UQ_W;           // |strength| * unit component
	// softening floor on the squared distance: 0.6 with 2F fraction bits
	localparam logic [SQW-1:0] FLOOR_D2 = SQW'((64'd3 << (2 * FRAC_BITS)) / 64'd5);

	// sideband carried around the square root
	typedef struct packed {
		logic [MW-1:0]         ax;
		logic [MW-1:0]         ay;
		logic                  neg_x;
		logic                  neg_y;
		logic signed [CW-1:0]  vel_x;
		logic signed [CW-1:0]  vel_y;
		logic                  reach;
	} sb_a_t;

	// sideband carried around the unit-vector divider
	typedef struct packed {
		logic [SQW-1:0]        sfl;
		logic                  dz;
		logic                  neg_x;
		logic                  neg_y;
		logic signed [CW-1:0]  vel_x;
		logic signed [CW-1:0]  vel_y;
		logic                  reach;
	} sb_b_t;

	// sideband carried around the kick divider; neg_* is the sign of the kick
	typedef struct packed {
		logic                  neg_x;
		logic                  neg_y;
		logic signed [CW-1:0]  vel_x;
		logic signed [CW-1:0]  vel_y;
		logic                  reach;
	} sb_c_t;

	function automatic logic signed [CW-1:0] sat_add(
		input logic signed [CW-1:0] v,
		input logic [KW-1:0]        m,
		input logic                 neg
	);
		logic signed [CW+1:0] a;
		logic signed [CW+1:0] s;
		a = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
		s = (CW+2)'(v) + a;
		if (s[CW+1:CW-1] == 3'b000 || s[CW+1:CW-1] == 3'b111) begin
			return s[CW-1:0];
		end
		return s[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	endfunction

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic signed [CW-1:0]        attractor_x_q;
	logic signed [CW-1:0]        attractor_y_q;
	logic signed [CW-1:0]        strength_q;
	logic [pavk_pkg::RAD_W-1:0]  effect_radius_q;
	logic [CW-1:0]               strength_mag_q;   // |strength|, 2^31 fits unsigned
	logic                        strength_neg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attractor_x_q   <= '0;
			attractor_y_q   <= '0;
			strength_q      <= '0;
			effect_radius_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pavk_pkg::CFG_ATTRACTOR_X:   attractor_x_q   <= cfg_data;
				pavk_pkg::CFG_ATTRACTOR_Y:   attractor_y_q   <= cfg_data;
				pavk_pkg::CFG_STRENGTH:      strength_q      <= cfg_data;
				pavk_pkg::CFG_EFFECT_RADIUS: effect_radius_q <= cfg_data[pavk_pkg::RAD_W-1:0];
				default:                     strength_q      <= strength_q;
			endcase
		end
	end

	// follows strength in the next cycle; config is idle long before use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_mag_q <= '0;
			strength_neg_q <= 1'b0;
		end else begin
			strength_mag_q <= strength_q[CW-1] ? CW'(-strength_q) : CW'(strength_q);
			strength_neg_q <= strength_q[CW-1];
		end
	end

	// ---------------------------------------------------------------
	// pipeline control: everything moves together, stalls only when
	// the output buffer is full and the last stage holds an item
	// ---------------------------------------------------------------
	logic en;
	logic v_s7;
	logic skid_space;
	logic push;

	assign en         = skid_space | ~v_s7;
	assign item_ready = en;
	assign push       = v_s7 & skid_space;

	// s1: deltas, exact in 33 bits
	logic                 v_s1;
	logic signed [CW:0]   dx_s1;
	logic signed [CW:0]   dy_s1;
	logic signed [CW-1:0] vel_x_s1;
	logic signed [CW-1:0] vel_y_s1;

	// s2: magnitudes and range check
	logic                 v_s2;
	sb_a_t                sb_s2;
	logic [CW:0]          mx_c;
	logic [CW:0]          my_c;

	// s3: squares
	logic                 v_s3;
	sb_a_t                sb_s3;
	logic [2*MW-1:0]      axx_s3;
	logic [2*MW-1:0]      ayy_s3;
	logic [2*MW-1:0]      r2_s3;

	// s4: squared distance and radius test
	logic                 v_s4;
	sb_a_t                sb_s4;
	sb_a_t                sb_a_c;
	logic [SQW-1:0]       sum_s4;
	logic [SQW-1:0]       sum_c;

	// root pipeline outputs
	logic                 rt_valid;
	logic [RTW-1:0]       rt_root;
	logic [2*RTW-1:0]     rt_val;
	logic [$bits(sb_a_t)-1:0] rt_sb_vec;
	sb_a_t                rt_sb;

	// s5: floor, divider operands
	logic                 v_s5;
	logic [RTW-1:0]       d_s5;
	logic [1:0][RTW-1:0]  uhi_s5;
	logic [1:0][UQ_W-1:0] ulo_s5;
	sb_b_t                sb_s5;

	// unit divider outputs
	logic                 ud_valid;
	logic [1:0][UQ_W-1:0] ud_q;
	logic [$bits(sb_b_t)-1:0] ud_sb_vec;
	sb_b_t                ud_sb;
	logic [UQ_W-1:0]      ux_c;
	logic [UQ_W-1:0]      uy_c;

	// s6: strength times unit component
	logic                 v_s6;
	logic [NUM_W-1:0]     num_x_s6;
	logic [NUM_W-1:0]     num_y_s6;
	logic [SQW-1:0]       sfl_s6;
	sb_c_t                sb_s6;
	logic [1:0][SQW-1:0]  khi_c;
	logic [1:0][KW-1:0]   klo_c;

	// kick divider outputs; quotient stays below 2^32 because d2 >= 0.6
	logic                 kd_valid;
	logic [1:0][KW-1:0]   kd_q;
	logic [$bits(sb_c_t)-1:0] kd_sb_vec;
	sb_c_t                kd_sb;

	// s7: saturating add and select
	pavk_pkg::result_t    result_s7;
	logic [$bits(pavk_pkg::result_t)-1:0] out_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= rt_valid;
			v_s6 <= ud_valid;
			v_s7 <= kd_valid;
		end
	end

	assign mx_c  = dx_s1[CW] ? (CW+1)'(-dx_s1) : (CW+1)'(dx_s1);
	assign my_c  = dy_s1[CW] ? (CW+1)'(-dy_s1) : (CW+1)'(dy_s1);
	assign sum_c = SQW'(axx_s3) + SQW'(ayy_s3);

	// radius test folded into the sideband
	always_comb begin
		sb_a_c       = sb_s3;
		sb_a_c.reach = sb_s3.reach && (sum_c <= SQW'(r2_s3));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= (CW+1)'(attractor_x_q) - (CW+1)'(item.pos_x);
			dy_s1    <= (CW+1)'(attractor_y_q) - (CW+1)'(item.pos_y);
			vel_x_s1 <= item.vel_x;
			vel_y_s1 <= item.vel_y;

			sb_s2.ax     <= mx_c[MW-1:0];
			sb_s2.ay     <= my_c[MW-1:0];
			sb_s2.neg_x  <= dx_s1[CW];
			sb_s2.neg_y  <= dy_s1[CW];
			sb_s2.vel_x  <= vel_x_s1;
			sb_s2.vel_y  <= vel_y_s1;
			// a delta of 2^31 or more cannot be inside the largest radius
			sb_s2.reach  <= (mx_c[CW:MW] == '0) && (my_c[CW:MW] == '0);

			sb_s3  <= sb_s2;
			axx_s3 <= sb_s2.ax * sb_s2.ax;
			ayy_s3 <= sb_s2.ay * sb_s2.ay;
			r2_s3  <= effect_radius_q * effect_radius_q;

			sb_s4  <= sb_a_c;
			sum_s4 <= sum_c;
		end
	end

	pavk_isqrt #(
		.RTW (RTW),
		.SW  ($bits(sb_a_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_val    ((2*RTW)'(sum_s4)),
		.in_sb     (sb_s4),
		.out_valid (rt_valid),
		.out_root  (rt_root),
		.out_val   (rt_val),
		.out_sb    (rt_sb_vec)
	);

	assign rt_sb = sb_a_t'(rt_sb_vec);

	// unit component: (|delta| << F) / d, the dividend top is |delta| >> 1 < d
	always_ff @(posedge clk) begin
		if (en) begin
			d_s5      <= rt_root;
			uhi_s5[0] <= RTW'(rt_sb.ax >> 1);
			uhi_s5[1] <= RTW'(rt_sb.ay >> 1);
			ulo_s5[0] <= {rt_sb.ax[0], {FRAC_BITS{1'b0}}};
			ulo_s5[1] <= {rt_sb.ay[0], {FRAC_BITS{1'b0}}};
			sb_s5.sfl <= (rt_val[SQW-1:0] < FLOOR_D2) ? FLOOR_D2 : rt_val[SQW-1:0];
			sb_s5.dz  <= rt_root == '0;
			sb_s5.neg_x  <= rt_sb.neg_x;
			sb_s5.neg_y  <= rt_sb.neg_y;
			sb_s5.vel_x  <= rt_sb.vel_x;
			sb_s5.vel_y  <= rt_sb.vel_y;
			sb_s5.reach  <= rt_sb.reach;
		end
	end

	pavk_div #(
		.DENW  (RTW),
		.QW    (UQ_W),
		.LANES (2),
		.SW    ($bits(sb_b_t))
	) u_udiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_den    (d_s5),
		.in_hi     (uhi_s5),
		.in_lo     (ulo_s5),
		.in_sb     (sb_s5),
		.out_valid (ud_valid),
		.out_q     (ud_q),
		.out_sb    (ud_sb_vec)
	);

	assign ud_sb = sb_b_t'(ud_sb_vec);
	// zero distance: no direction, no kick
	assign ux_c  = ud_sb.dz ? '0 : ud_q[0];
	assign uy_c  = ud_sb.dz ? '0 : ud_q[1];

	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s6     <= strength_mag_q * ux_c;
			num_y_s6     <= strength_mag_q * uy_c;
			sfl_s6       <= ud_sb.sfl;
			sb_s6.neg_x  <= ud_sb.neg_x ^ strength_neg_q;
			sb_s6.neg_y  <= ud_sb.neg_y ^ strength_neg_q;
			sb_s6.vel_x  <= ud_sb.vel_x;
			sb_s6.vel_y  <= ud_sb.vel_y;
			sb_s6.reach  <= ud_sb.reach;
		end
	end

	// kick = (num << F) / d2; dividend top is num >> (32 - F), below d2
	assign khi_c[0] = SQW'(num_x_s6 >> (KW - FRAC_BITS));
	assign khi_c[1] = SQW'(num_y_s6 >> (KW - FRAC_BITS));
	assign klo_c[0] = {num_x_s6[KW-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
	assign klo_c[1] = {num_y_s6[KW-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};

	pavk_div #(
		.DENW  (SQW),
		.QW    (KW),
		.LANES (2),
		.SW    ($bits(sb_c_t))
	) u_kdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_den    (sfl_s6),
		.in_hi     (khi_c),
		.in_lo     (klo_c),
		.in_sb     (sb_s6),
		.out_valid (kd_valid),
		.out_q     (kd_q),
		.out_sb    (kd_sb_vec)
	);

	assign kd_sb = sb_c_t'(kd_sb_vec);

	// outside the radius the velocity passes through untouched
	always_ff @(posedge clk) begin
		if (en) begin
			result_s7.new_vel_x    <= kd_sb.reach ? sat_add(kd_sb.vel_x, kd_q[0], kd_sb.neg_x)
			                                      : kd_sb.vel_x;
			result_s7.new_vel_y    <= kd_sb.reach ? sat_add(kd_sb.vel_y, kd_q[1], kd_sb.neg_y)
			                                      : kd_sb.vel_y;
			result_s7.within_reach <= kd_sb.reach;
		end
	end

	pavk_skid #(
		.W ($bits(pavk_pkg::result_t))
	) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result_s7),
		.space     (skid_space),
		.valid     (result_valid),
		.ready     (result_ready),
		.data      (out_vec)
	);

	assign result = pavk_pkg::result_t'(out_vec);

endmodule
`default_nettype wire

// File: test/pavk_checker.sv
`timescale 1ns / 1ps
module pavk_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_ready,
	input  pavk_pkg::item_t              item,
	input  logic                         result_valid,
	input  logic                         result_ready,
	input  pavk_pkg::result_t            result,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  pavk_pkg::cfg_idx_t           cfg_index,
	input  logic [pavk_pkg::COORD_W-1:0] cfg_data,
	output int                           mismatches,
	output int                           waiting
);

	localparam int F = pavk_pkg::FRAC_BITS_DEF;
	localparam longint unsigned KICK_CAP = 64'd1 << 40;

	logic signed [31:0] att_x, att_y, pull;
	logic [30:0]        radius;
	pavk_pkg::result_t  velocity_q[$];

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint kick_of(longint delta, longint unsigned d, longint f,
			longint unsigned den);
		longint unsigned u, m, ad, af;
		if (d == 0 || delta == 0 || f == 0)
			return 0;
		ad = delta < 0 ? -delta : delta;
		af = f < 0 ? -f : f;
		u = (ad << F) / d;
		// num < 2^48, so the scaled quotient fits in 64 bits
		m = ((af * u) << F) / den;
		if (m > KICK_CAP)
			m = KICK_CAP;
		return ((delta < 0) != (f < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [31:0] sat_add(longint v, longint k);
		longint s;
		s = v + k;
		if (s > 64'sh7FFFFFFF)
			s = 64'sh7FFFFFFF;
		if (s < -64'sh80000000)
			s = -64'sh80000000;
		return s[31:0];
	endfunction

	function automatic pavk_pkg::result_t kicked_velocity(pavk_pkg::item_t it);
		pavk_pkg::result_t r;
		longint dx, dy;
		longint unsigned ax, ay, s, d, den, floor_d2;
		dx = longint'(att_x) - longint'(it.pos_x);
		dy = longint'(att_y) - longint'(it.pos_y);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		r.new_vel_x = it.vel_x;
		r.new_vel_y = it.vel_y;
		r.within_reach = 1'b0;
		if (ax >= 64'h80000000 || ay >= 64'h80000000)
			return r;
		s = ax * ax + ay * ay;
		if (s > longint'(radius) * longint'(radius))
			return r;
		d = isqrt(s);
		floor_d2 = (64'd3 << (2 * F)) / 5;
		den = s < floor_d2 ? floor_d2 : s;
		r.new_vel_x = sat_add(longint'(it.vel_x), kick_of(dx, d, longint'(pull), den));
		r.new_vel_y = sat_add(longint'(it.vel_y), kick_of(dy, d, longint'(pull), den));
		r.within_reach = 1'b1;
		return r;
	endfunction

	assign waiting = velocity_q.size();

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_x <= '0;
			att_y <= '0;
			pull <= '0;
			radius <= '0;
			mismatches <= 0;
			velocity_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pavk_pkg::CFG_ATTRACTOR_X:   att_x <= cfg_data;
					pavk_pkg::CFG_ATTRACTOR_Y:   att_y <= cfg_data;
					pavk_pkg::CFG_STRENGTH:      pull <= cfg_data;
					pavk_pkg::CFG_EFFECT_RADIUS: radius <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready)
				velocity_q.push_back(kicked_velocity(item));
			if (result_valid && result_ready) begin
				if (velocity_q.size() == 0) begin
					$error("unexpected result %h", result);
					mismatches <= mismatches + 1;
				end else begin
					pavk_pkg::result_t e;
					e = velocity_q.pop_front();
					if (result.new_vel_x !== e.new_vel_x)
						$error("new_vel_x expected %h actual %h", e.new_vel_x, result.new_vel_x);
					if (result.new_vel_y !== e.new_vel_y)
						$error("new_vel_y expected %h actual %h", e.new_vel_y, result.new_vel_y);
					if (result.within_reach !== e.within_reach)
						$error("within_reach expected %b actual %b", e.within_reach,
							result.within_reach);
					if (result !== e)
						mismatches <= mismatches + 1;
				end
			end
		end
	end
endmodule

// File: test/tb_point_attractor_velocity_kick_core.sv
`timescale 1ns / 1ps
module tb_point_attractor_velocity_kick_core;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	pavk_pkg::item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	pavk_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	pavk_pkg::cfg_idx_t cfg_index = pavk_pkg::CFG_ATTRACTOR_X;
	logic [31:0] cfg_data = '0;

	int mismatches, waiting;
	bit quiet = 1'b0;     // no idling on either side at the tail of the run
	int sent = 0, phases = 0;
	int stall_left = 0;
	// local copy of the attractor so random items can land near it
	logic signed [31:0] cur_ax, cur_ay;
	logic [30:0] cur_rad;

	always #5 clk = ~clk;

	point_attractor_velocity_kick_core uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pavk_checker chk (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .waiting(waiting)
	);

	// Receiver backpressure: result_ready is dropped in random stall bursts.
	always @(posedge clk) begin
		if (!arst_n || quiet) begin
			result_ready <= arst_n;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			result_ready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Tasks start and end right after a rising edge. Ready is sampled on the
	// falling edge, where it is stable for the next rising edge.
	task automatic send_item(pavk_pkg::item_t it);
		bit ok;
		item_valid <= 1'b1;
		item <= it;
		do begin
			@(negedge clk);
			ok = item_ready;
			@(posedge clk);
		end while (!ok);
		sent++;
		// sender gap: item_valid drops for a random idle burst now and then
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic write_reg(pavk_pkg::cfg_idx_t idx, logic [31:0] data);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
	endtask

	// Registers change only once the pipeline has drained.
	task automatic set_field(logic [31:0] ax, logic [31:0] ay, logic [31:0] st,
			logic [31:0] rad);
		item_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		write_reg(pavk_pkg::CFG_ATTRACTOR_X, ax);
		write_reg(pavk_pkg::CFG_ATTRACTOR_Y, ay);
		write_reg(pavk_pkg::CFG_STRENGTH, st);
		write_reg(pavk_pkg::CFG_EFFECT_RADIUS, rad);
		cur_ax = ax;
		cur_ay = ay;
		cur_rad = rad[30:0];
		phases++;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return 32'hFFFFFFFF;
			default: return $urandom();
		endcase
	endfunction

	// Offset from the attractor, mostly within reach of the current radius.
	function automatic logic [31:0] near_offset();
		logic [31:0] mag;
		int sh;
		sh = $urandom_range(0, 31);
		mag = $urandom() >> sh;
		if ($urandom_range(0, 3) != 0)
			mag = (cur_rad == 0) ? 32'd0 : $urandom_range(0, cur_rad) >> 1;
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	function automatic pavk_pkg::item_t rand_item();
		pavk_pkg::item_t it;
		if ($urandom_range(0, 4) == 0) begin
			it.pos_x = rand_word();
			it.pos_y = rand_word();
		end else begin
			it.pos_x = cur_ax + near_offset();
			it.pos_y = cur_ay + near_offset();
		end
		it.vel_x = rand_word();
		it.vel_y = rand_word();
		return it;
	endfunction

	initial begin
		pavk_pkg::item_t it;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: attractor at origin, widest radius, unit strength.
		set_field(32'h0, 32'h0, 32'h0001_0000, 32'h7FFF_FFFF);
		send_item('{32'h0, 32'h0, 32'h1234_5678, 32'h8765_4321});        // zero distance
		send_item('{32'h0000_0100, 32'h0, 32'h0, 32'h0});                 // softening floor
		send_item('{32'h0, 32'hFFFF_FF00, 32'h0, 32'h0});
		send_item('{32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000});
		send_item('{32'h8000_0000, 32'h0, 32'h0, 32'h0});                 // |dx| = 2^31
		send_item('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF});
		send_item('{32'h8000_0001, 32'h0, 32'h0, 32'h0});
		// Extreme strength, attractor far corner: saturation and out of range.
		set_field(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		send_item('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
		send_item('{32'h7FFF_FF00, 32'h8000_0100, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		send_item('{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0});
		send_item('{32'h0, 32'h0, 32'h0, 32'h0});
		// Max strength, zero radius: only an exact hit is within reach.
		set_field(32'h0003_0000, 32'hFFFD_0000, 32'h7FFF_FFFF, 32'h0);
		send_item('{32'h0003_0000, 32'hFFFD_0000, 32'h5, 32'h6});
		send_item('{32'h0003_0001, 32'hFFFD_0000, 32'h5, 32'h6});
		send_item('{32'h0002_0000, 32'hFFFC_0000, 32'h8000_0000, 32'h7FFF_FFFF});
		// Modest radius: points on both sides of the boundary.
		set_field(32'h0, 32'h0, 32'hFFFF_0000, 32'h0002_0000);
		send_item('{32'h0002_0000, 32'h0, 32'h0, 32'h0});
		send_item('{32'h0002_0001, 32'h0, 32'h0, 32'h0});
		send_item('{32'h0001_6A09, 32'h0001_6A09, 32'h0, 32'h0});
		send_item('{32'h0, 32'hFFFE_0000, 32'h0, 32'h0});

		// Random phases with fresh register settings.
		while (sent < 1650) begin
			logic [31:0] st, rad;
			case ($urandom_range(0, 3))
				0: st = rand_word();
				1: st = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
				default: st = $urandom();
			endcase
			rad = $urandom() >> $urandom_range(0, 20);
			if ($urandom_range(0, 5) == 0)
				rad = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			if (sent > 1450)
				quiet = 1'b1;
			set_field(rand_word(), rand_word(), st, rad);
			repeat ($urandom_range(40, 160)) begin
				it = rand_item();
				send_item(it);
			end
		end
		item_valid <= 1'b0;

		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d particles across %0d attractor settings, with idle and", sent,
			phases);
		$display("stall bursts on both channels and extreme positions and velocities.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+sv
sv/pavk_pkg.sv
sv/pavk_isqrt.sv
sv/pavk_div.sv
sv/pavk_skid.sv
sv/point_attractor_velocity_kick_core.sv
test/pavk_checker.sv
test/tb_point_attractor_velocity_kick_core.sv
